>>> rtl/occ_tree_pkg.sv
// Shared constants and types of the occupancy tree block.
`timescale 1ns / 1ps
package occ_tree_pkg;

	localparam int SLOTS = 1024;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int ADDR_W = SLOT_W + 1;
	localparam int NODE_W = SLOT_W + 2;
	localparam int DEPTH = 2 * SLOTS;

	localparam int SLOT_IDX_W = 10;
	localparam int RANGE_W = 11;

	localparam logic KIND_MARK = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_M_CHK,
		ST_M_UP,
		ST_M_WR,
		ST_Q_LO,
		ST_Q_HI
	} occ_state_t;

endpackage

>>> rtl/occ_tree_req_if.sv
// Request channel carrying mark and query transactions.
`timescale 1ns / 1ps
interface occ_tree_req_if;
	logic valid;
	logic ready;
	logic kind;
	logic [occ_tree_pkg::SLOT_IDX_W-1:0] slot_index;
	logic [occ_tree_pkg::RANGE_W-1:0] range_start;
	logic [occ_tree_pkg::RANGE_W-1:0] range_end;

	modport source (output valid, kind, slot_index, range_start, range_end, input ready);
	modport sink (input valid, kind, slot_index, range_start, range_end, output ready);
endinterface

>>> rtl/occ_tree_rsp_if.sv
// Response channel carrying query answers.
`timescale 1ns / 1ps
interface occ_tree_rsp_if;
	logic valid;
	logic ready;
	logic all_set;

	modport source (output valid, all_set, input ready);
	modport sink (input valid, all_set, output ready);
endinterface

>>> rtl/occupancy_tree_range_all_set_unit.sv
// Occupancy bitmap held as a tree of AND bits, with slot marking and range queries.
`timescale 1ns / 1ps
// The tree lives in one 2*SLOTS by 1 bit memory with a synchronous read.
// After reset the block clears that memory, one entry a cycle, and accepts
// no transaction until every entry is clear.
// A mark transaction ends after one read when the slot is already set; otherwise
// it climbs the tree with one read and one write per tree level.
// A query transaction makes at most two memory reads per tree level on the single
// read port; an empty range or one past the slot count is answered without a read,
// with all_set clear. Each query gives one response transaction; marks give none.
// A finished answer sits in an output register, so a new transaction can be taken
// while the previous answer waits.
module occupancy_tree_range_all_set_unit (
	input logic clk,
	input logic arst_n,
	occ_tree_req_if.sink req,
	occ_tree_rsp_if.source rsp
);

	logic tree_mem [occ_tree_pkg::DEPTH];

	occ_tree_pkg::occ_state_t state_q, state_d;
	logic [occ_tree_pkg::NODE_W-1:0] node_q, node_d;
	logic [occ_tree_pkg::NODE_W-1:0] lo_q, lo_d;
	logic [occ_tree_pkg::NODE_W-1:0] hi_q, hi_d;
	logic [occ_tree_pkg::NODE_W-1:0] hi_dec;
	logic [occ_tree_pkg::ADDR_W-1:0] clr_q, clr_d;
	logic acc_q, acc_d, acc_in;
	logic pend_q, pend_d;
	logic rdata_q;
	logic out_valid_q, all_set_q, out_load, out_free;

	logic mem_we, mem_wdata, mem_re;
	logic [occ_tree_pkg::ADDR_W-1:0] mem_waddr, mem_raddr;

	logic slot_ok, range_ok;

	assign acc_in = acc_q & (~pend_q | rdata_q);
	assign out_free = ~out_valid_q | rsp.ready;
	assign slot_ok = 32'(req.slot_index) < 32'(occ_tree_pkg::SLOTS);
	assign range_ok = (32'(req.range_start) < 32'(req.range_end)) &&
		(32'(req.range_end) <= 32'(occ_tree_pkg::SLOTS));

	always_comb begin
		state_d = state_q;
		node_d = node_q;
		lo_d = lo_q;
		hi_d = hi_q;
		hi_dec = hi_q;
		clr_d = clr_q;
		acc_d = acc_q;
		pend_d = pend_q;
		mem_we = 1'b0;
		mem_wdata = 1'b0;
		mem_waddr = node_q[occ_tree_pkg::ADDR_W-1:0];
		mem_re = 1'b0;
		mem_raddr = '0;
		out_load = 1'b0;
		req.ready = 1'b0;
		unique case (state_q)
			occ_tree_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				mem_waddr = clr_q;
				clr_d = clr_q + 1'b1;
				if (&clr_q) begin
					state_d = occ_tree_pkg::ST_IDLE;
				end
			end
			occ_tree_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (req.kind == occ_tree_pkg::KIND_MARK) begin
						if (slot_ok) begin
							node_d = occ_tree_pkg::NODE_W'(32'(req.slot_index) +
								32'(occ_tree_pkg::SLOTS));
							mem_re = 1'b1;
							mem_raddr = node_d[occ_tree_pkg::ADDR_W-1:0];
							state_d = occ_tree_pkg::ST_M_CHK;
						end
					end else begin
						acc_d = 1'b1;
						pend_d = 1'b0;
						if (range_ok) begin
							lo_d = occ_tree_pkg::NODE_W'(32'(req.range_start) +
								32'(occ_tree_pkg::SLOTS));
							hi_d = occ_tree_pkg::NODE_W'(32'(req.range_end) +
								32'(occ_tree_pkg::SLOTS));
						end else begin
							acc_d = 1'b0;
							lo_d = occ_tree_pkg::NODE_W'(1);
							hi_d = '0;
						end
						state_d = occ_tree_pkg::ST_Q_LO;
					end
				end
			end
			occ_tree_pkg::ST_M_CHK: begin
				if (rdata_q) begin
					state_d = occ_tree_pkg::ST_IDLE;
				end else begin
					mem_we = 1'b1;
					mem_wdata = 1'b1;
					state_d = occ_tree_pkg::ST_M_UP;
				end
			end
			occ_tree_pkg::ST_M_UP: begin
				if (node_q == occ_tree_pkg::NODE_W'(1)) begin
					state_d = occ_tree_pkg::ST_IDLE;
				end else begin
					mem_re = 1'b1;
					mem_raddr = node_q[occ_tree_pkg::ADDR_W-1:0] ^ occ_tree_pkg::ADDR_W'(1);
					state_d = occ_tree_pkg::ST_M_WR;
				end
			end
			occ_tree_pkg::ST_M_WR: begin
				// The climbing node is set, so its parent takes the sibling's value.
				// A clear sibling leaves every ancestor clear, which they already are.
				mem_we = 1'b1;
				mem_waddr = node_q[occ_tree_pkg::ADDR_W:1];
				mem_wdata = rdata_q;
				node_d = node_q >> 1;
				state_d = rdata_q ? occ_tree_pkg::ST_M_UP : occ_tree_pkg::ST_IDLE;
			end
			occ_tree_pkg::ST_Q_LO: begin
				if (lo_q >= hi_q) begin
					if (out_free) begin
						out_load = 1'b1;
						state_d = occ_tree_pkg::ST_IDLE;
					end
				end else begin
					acc_d = acc_in;
					pend_d = lo_q[0];
					if (lo_q[0]) begin
						mem_re = 1'b1;
						mem_raddr = lo_q[occ_tree_pkg::ADDR_W-1:0];
						lo_d = lo_q + 1'b1;
					end
					state_d = occ_tree_pkg::ST_Q_HI;
				end
			end
			occ_tree_pkg::ST_Q_HI: begin
				acc_d = acc_in;
				pend_d = hi_q[0];
				if (hi_q[0]) begin
					hi_dec = hi_q - 1'b1;
					mem_re = 1'b1;
					mem_raddr = hi_dec[occ_tree_pkg::ADDR_W-1:0];
				end
				lo_d = lo_q >> 1;
				hi_d = hi_dec >> 1;
				state_d = occ_tree_pkg::ST_Q_LO;
			end
			default: begin
				state_d = occ_tree_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= occ_tree_pkg::ST_CLEAR;
			clr_q <= '0;
			pend_q <= 1'b0;
			acc_q <= 1'b0;
			node_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q <= clr_d;
			pend_q <= pend_d;
			acc_q <= acc_d;
			node_q <= node_d;
			lo_q <= lo_d;
			hi_q <= hi_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			all_set_q <= acc_in;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tree_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= tree_mem[mem_raddr];
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.all_set = all_set_q;

endmodule

>>> tb/sv/occ_tree_checker.sv
// Checker that watches both channels, predicts each query answer and compares it.
`timescale 1ns / 1ps
module occ_tree_checker (
	input logic clk,
	input logic arst_n,
	occ_tree_req_if req,
	occ_tree_rsp_if rsp,
	output int answers_waiting,
	output int fail_count
);

	bit marked [occ_tree_pkg::SLOTS];
	bit answer_q [$];
	bit expected;
	int mismatches;

	function automatic bit span_all_marked(input logic [occ_tree_pkg::RANGE_W-1:0] first,
		input logic [occ_tree_pkg::RANGE_W-1:0] last);
		int unsigned lo;
		int unsigned hi;
		int unsigned s;
		bit acc;
		lo = 32'(first);
		hi = 32'(last);
		if (lo >= hi || hi > 32'(occ_tree_pkg::SLOTS)) begin
			return 1'b0;
		end
		acc = 1'b1;
		for (s = lo; s < hi; s++) begin
			acc &= marked[s];
		end
		return acc;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (marked[i]) begin
				marked[i] = 1'b0;
			end
			answer_q.delete();
			mismatches = 0;
			answers_waiting <= 0;
			fail_count <= 0;
		end else begin
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				if (answer_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Unexpected response transaction at %0t: all_set %0b.",
							$time, rsp.all_set);
					end
				end else begin
					expected = answer_q.pop_front();
					if (rsp.all_set !== expected) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("Mismatch at %0t: all_set expected %0b, actual %0b.",
								$time, expected, rsp.all_set);
						end
					end
				end
			end
			if (req.valid === 1'b1 && req.ready === 1'b1) begin
				if (req.kind == occ_tree_pkg::KIND_MARK) begin
					if (32'(req.slot_index) < 32'(occ_tree_pkg::SLOTS)) begin
						marked[req.slot_index] = 1'b1;
					end
				end else begin
					answer_q.push_back(span_all_marked(req.range_start, req.range_end));
				end
			end
			answers_waiting <= answer_q.size();
			fail_count <= mismatches;
		end
	end
endmodule

>>> tb/sv/tb.sv
// Testbench top that drives mark and query transactions into the occupancy tree block.
`timescale 1ns / 1ps
module tb;

	logic clk = 1'b0;
	logic arst_n;
	int idle_pct;
	int stall_pct;
	int sent_count;
	int answers_waiting;
	int fail_count;
	int idle_plan [4] = '{0, 46, 0, 24};
	int stall_plan [4] = '{0, 0, 46, 24};

	occ_tree_req_if req_ch ();
	occ_tree_rsp_if rsp_ch ();

	occupancy_tree_range_all_set_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	occ_tree_checker checker_inst (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.answers_waiting(answers_waiting),
		.fail_count(fail_count)
	);

	always #10 clk = ~clk;

	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	task automatic issue(input logic kind, input int slot, input int first, input int last);
		while ($urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind <= kind;
		if (kind == occ_tree_pkg::KIND_MARK) begin
			req_ch.slot_index <= occ_tree_pkg::SLOT_IDX_W'(slot);
			req_ch.range_start <= occ_tree_pkg::RANGE_W'($urandom);
			req_ch.range_end <= occ_tree_pkg::RANGE_W'($urandom);
		end else begin
			req_ch.slot_index <= occ_tree_pkg::SLOT_IDX_W'($urandom);
			req_ch.range_start <= occ_tree_pkg::RANGE_W'(first);
			req_ch.range_end <= occ_tree_pkg::RANGE_W'(last);
		end
		@(posedge clk);
		while (req_ch.ready !== 1'b1) begin
			@(posedge clk);
		end
		sent_count++;
	endtask

	// Holds the request channel quiet until every answer has been taken and any mark has settled.
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (answers_waiting != 0) begin
			@(posedge clk);
		end
		repeat (30) @(posedge clk);
	endtask

	initial begin
		int base;
		int span;
		int lo;
		int hi;
		int choice;
		int phase;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.kind <= occ_tree_pkg::KIND_MARK;
		req_ch.slot_index <= '0;
		req_ch.range_start <= '0;
		req_ch.range_end <= '0;
		stall_pct <= 0;
		idle_pct = 0;
		sent_count = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(occ_tree_pkg::KIND_QUERY, 0, 0, 0);
		issue(occ_tree_pkg::KIND_QUERY, 0, 1024, 1024);
		issue(occ_tree_pkg::KIND_QUERY, 0, 5, 3);
		issue(occ_tree_pkg::KIND_QUERY, 0, 0, 1024);
		issue(occ_tree_pkg::KIND_QUERY, 0, 0, 2047);
		issue(occ_tree_pkg::KIND_QUERY, 0, 1024, 2047);
		issue(occ_tree_pkg::KIND_MARK, 0, 0, 0);
		issue(occ_tree_pkg::KIND_MARK, 1023, 0, 0);
		issue(occ_tree_pkg::KIND_MARK, 0, 0, 0);
		issue(occ_tree_pkg::KIND_QUERY, 0, 0, 1);
		issue(occ_tree_pkg::KIND_QUERY, 0, 1023, 1024);
		issue(occ_tree_pkg::KIND_QUERY, 0, 0, 2);
		issue(occ_tree_pkg::KIND_QUERY, 0, 1023, 1025);
		issue(occ_tree_pkg::KIND_MARK, 1, 0, 0);
		issue(occ_tree_pkg::KIND_QUERY, 0, 0, 2);
		issue(occ_tree_pkg::KIND_QUERY, 0, 1, 1);
		issue(occ_tree_pkg::KIND_QUERY, 0, 1022, 1024);
		issue(occ_tree_pkg::KIND_MARK, 1022, 0, 0);
		issue(occ_tree_pkg::KIND_QUERY, 0, 1022, 1024);
		issue(occ_tree_pkg::KIND_MARK, 682, 0, 0);
		issue(occ_tree_pkg::KIND_QUERY, 0, 682, 683);
		issue(occ_tree_pkg::KIND_QUERY, 0, 681, 684);
		drain();

		for (phase = 0; phase < 4; phase++) begin
			idle_pct = idle_plan[phase];
			stall_pct <= stall_plan[phase];
			while (sent_count < 25 + 150 * (phase + 1)) begin
				choice = $urandom_range(99);
				if (choice < 60) begin
					span = $urandom_range(1, 12);
					base = $urandom_range(occ_tree_pkg::SLOTS - 1);
					if (base + span > occ_tree_pkg::SLOTS) begin
						base = occ_tree_pkg::SLOTS - span;
					end
					for (int i = 0; i < span; i++) begin
						if ($urandom_range(99) < 85) begin
							issue(occ_tree_pkg::KIND_MARK, base + i, 0, 0);
						end
					end
					repeat (3) begin
						lo = base + $urandom_range(span - 1);
						hi = $urandom_range(lo + 1, base + span);
						issue(occ_tree_pkg::KIND_QUERY, 0, lo, hi);
					end
					issue(occ_tree_pkg::KIND_QUERY, 0, (base > 0) ? base - 1 : 0,
						base + span + 1);
				end else if (choice < 80) begin
					issue(occ_tree_pkg::KIND_MARK, $urandom_range(occ_tree_pkg::SLOTS - 1),
						0, 0);
				end else if (choice < 90) begin
					lo = $urandom_range(occ_tree_pkg::SLOTS);
					issue(occ_tree_pkg::KIND_QUERY, 0, lo, lo + $urandom_range(64));
				end else begin
					issue(occ_tree_pkg::KIND_QUERY, 0, $urandom_range(occ_tree_pkg::SLOTS),
						$urandom_range(2047));
				end
			end
			drain();
		end

		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
